FILE: rtl/stbs_pkg.sv
package stbs_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int POS_W   = 11;
    localparam int KIND_W  = 2;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    localparam kind_t KIND_WRITE = 2'd0;
    localparam kind_t KIND_FIND  = 2'd1;
    localparam kind_t KIND_LOWER = 2'd2;
    localparam kind_t KIND_UPPER = 2'd3;

endpackage

FILE: rtl/sorted_table_binary_search_unit.sv
// Sorted-table search unit.
// The slave stream (s_tvalid, s_tready, s_tdata, s_tuser) carries items. An item of
// the write kind stores one signed entry at entry_index and gives no result. A query
// item (exact find, lower bound, upper bound) searches entries 0..n-1, with n the
// entry_count capped at min(TABLE_DEPTH, 2047), and gives one result on the master
// stream (m_tvalid, m_tready, m_tdata, m_tuser). entry_count is loaded through the
// cfg_valid/cfg_ready/cfg_data channel, which is always ready; the user must change
// it only while no query is in flight, and the block does not enforce this. A query
// reads one table entry per cycle from a synchronous RAM with a registered read and
// a separate write port: the first probe is read as the item is accepted, and each
// search step compares the returned entry and either ends or reads the next probe.
// The next item is accepted as soon as the result has moved into the output
// register, even while that result still waits for m_tready.
// If the receiver stalls and the output register is still full when a search
// finishes, the search holds its final probe until the register frees up.
// Reset clears entry_count, the control state and the output valid flag; the table
// contents are undefined until written.
module sorted_table_binary_search_unit
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,    // entry_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // entry_index [9:0], value [41:10], zeros above
    input  logic [1:0]  s_tuser,     // kind [1:0]
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] m_tdata,     // position [10:0], zeros above
    output logic [0:0]  m_tuser      // found [0]
);

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EXT_W   = (ADDR_W > POS_W) ? ADDR_W : POS_W;
    localparam int CAP_INT = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
    localparam pos_t DEPTH_CAP = POS_W'(CAP_INT);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic                state_reg, state_next;
    kind_t               mode_reg, mode_next;
    value_t              key_reg, key_next;
    pos_t                left_reg, left_next;
    pos_t                hi_reg, hi_next;
    pos_t                mid_reg, mid_next;
    logic                empty_reg, empty_next;
    pos_t                count_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg;
    pos_t                out_pos_reg;

    value_t              mem [TABLE_DEPTH];
    value_t              rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;

    kind_t               in_kind;
    logic [INDEX_W-1:0]  in_index;
    value_t              in_value;
    logic                s_accept;
    pos_t                n_used;
    pos_t                init_mid;
    logic                hit;
    logic                go_right;
    pos_t                cmp_left;
    pos_t                cmp_hi;
    logic [POS_W:0]      mid_sum;
    pos_t                cmp_mid;
    logic                done;
    logic                load_ok;
    logic                load;
    logic                res_found;
    pos_t                res_pos;

    assign in_kind  = s_tuser;
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;

    assign n_used   = (count_reg > DEPTH_CAP) ? DEPTH_CAP : count_reg;
    assign init_mid = (n_used - POS_W'(1)) >> 1;

    assign wr_en   = s_accept && (in_kind == KIND_WRITE)
                     && (32'(in_index) < TABLE_DEPTH);
    assign wr_addr = ADDR_W'(EXT_W'(in_index));

    // One probe step: compare the returned entry and narrow the range [left, hi).
    always_comb
    begin
        hit      = (mode_reg == KIND_FIND) && (rd_data_reg == key_reg);
        go_right = (mode_reg == KIND_UPPER) ? (rd_data_reg <= key_reg)
                                            : (rd_data_reg < key_reg);
        if (go_right)
        begin
            cmp_left = mid_reg + POS_W'(1);
            cmp_hi   = hi_reg;
        end
        else
        begin
            cmp_left = left_reg;
            cmp_hi   = mid_reg;
        end
        mid_sum = {1'b0, cmp_left} + {1'b0, cmp_hi} - (POS_W+1)'(1);
        cmp_mid = mid_sum[POS_W:1];

        done = empty_reg || hit || (cmp_left >= cmp_hi);
        if (empty_reg)
        begin
            res_found = 1'b0;
            res_pos   = (mode_reg == KIND_FIND) ? '0 : left_reg;
        end
        else if (hit)
        begin
            res_found = 1'b1;
            res_pos   = mid_reg;
        end
        else
        begin
            res_found = 1'b0;
            res_pos   = (mode_reg == KIND_FIND) ? '0 : cmp_left;
        end
    end

    assign load_ok = !out_valid_reg || m_tready;
    assign load    = (state_reg == S_SEARCH) && done && load_ok;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        left_next  = left_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        empty_next = empty_reg;
        rd_addr    = ADDR_W'(EXT_W'(mid_reg));
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = ADDR_W'(EXT_W'(init_mid));
                if (s_accept && (in_kind != KIND_WRITE))
                begin
                    state_next = S_SEARCH;
                    mode_next  = in_kind;
                    key_next   = in_value;
                    left_next  = '0;
                    hi_next    = n_used;
                    mid_next   = init_mid;
                    empty_next = (n_used == '0);
                end
            end
            S_SEARCH:
            begin
                if (!done)
                begin
                    left_next = cmp_left;
                    hi_next   = cmp_hi;
                    mid_next  = cmp_mid;
                    rd_addr   = ADDR_W'(EXT_W'(cmp_mid));
                end
                else if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            empty_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        key_reg  <= key_next;
        left_reg <= left_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        if (load)
        begin
            out_found_reg <= res_found;
            out_pos_reg   <= res_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-POS_W){1'b0}}, out_pos_reg};
    assign m_tuser  = out_found_reg;

`ifndef ASSERT_OFF
    a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) && !empty_reg |-> left_reg < hi_reg)
        else $error("search range is empty while probing");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) && !empty_reg |-> (mid_reg >= left_reg) && (mid_reg < hi_reg))
        else $error("probe index outside the search range");

    a_hi_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> hi_reg <= n_used)
        else $error("search range exceeds the used entries");

    a_found_only_find: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_found |-> mode_reg == KIND_FIND)
        else $error("found flag set by a bound query");

    a_bound_limit: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> res_pos <= n_used)
        else $error("result position beyond the used entries");
`endif

endmodule
